[sv/pdc_pkg.sv]
package pdc_pkg;

    localparam int STAMP_W     = 24;
    localparam int PERIOD_W    = STAMP_W + 1;
    localparam int FREQ_W      = 24;
    localparam int DUTY_W      = 7;
    localparam int PROD_W      = 31;
    localparam int STEP_W      = 5;
    localparam int TPS_W       = 24;
    localparam int MAXP_W      = 10;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 1;

    localparam int DEF_MAX_PERIODS_LIMIT = 512;

    localparam logic [TPS_W-1:0]  TPS_RESET  = TPS_W'(1000000);
    localparam logic [MAXP_W-1:0] MAXP_RESET = MAXP_W'(512);
    localparam logic [PROD_W-1:0] DUTY_SCALE = PROD_W'(100);

    localparam logic [STEP_W-1:0] FREQ_STEPS = STEP_W'(24);
    localparam logic [STEP_W-1:0] DUTY_STEPS = STEP_W'(7);

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIODS      = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [STAMP_W-1:0] edge_time;
    } pdc_in_t;

    typedef struct packed {
        logic [STAMP_W-1:0] high_ticks;
        logic [STAMP_W-1:0] low_ticks;
        logic [FREQ_W-1:0]  frequency;
        logic [DUTY_W-1:0]  duty_percent;
        logic               period_error;
        logic               last_period;
    } pdc_out_t;

    // one division request to the shared divider
    typedef struct packed {
        logic                start;
        logic [STEP_W-1:0]   steps;
        logic [PERIOD_W-1:0] rem_init;
        logic [STAMP_W-1:0]  bits;
    } pdc_div_cmd_t;

endpackage

[sv/pwm_period_duty_capture_core.sv]
// pwm input capture: per-period high and low widths, frequency and duty
//
// s_ channel: words of {opcode, edge_time}. opcode start clears the capture
// state and arms it; opcode edge carries the down-counting timer stamp of an
// edge, alternating rising/falling, the first after start being rising.
// m_ channel: one word per rising edge that closes a period, holding high and
// low widths, frequency, duty, a zero-period error and the last-period mark.
// cfg port: write-only, index 0 ticks_per_second, index 1 max_periods.
//
// a start word or an edge that gives no result leaves s_ready high. a closing edge
// runs two divisions on one shared bit-serial divider: 24 steps for the
// frequency and 7 steps for the duty; s_ready returns in the same cycle that
// the result word becomes valid. a zero period skips the divider.
// the result sits in an output register; s_ready comes back once it is
// loaded, so a stalled receiver only holds the next closing edge.
// after reset capture is stopped until a start word arrives; the registers
// return to 1000000 ticks per second and 512 periods.
module pwm_period_duty_capture_core #(
    parameter int MAX_PERIODS_LIMIT = pdc_pkg::DEF_MAX_PERIODS_LIMIT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pdc_pkg::pdc_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pdc_pkg::pdc_out_t              m_data,
    input  logic                           cfg_wr_en,
    input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pdc_pkg::*;

    // counter wide enough to hold the limit itself
    localparam int CNT_W = $clog2(MAX_PERIODS_LIMIT + 1);
    localparam int CMP_W = (CNT_W + 1 > MAXP_W + 1) ? CNT_W + 1 : MAXP_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WAIT_F,
        ST_WAIT_D,
        ST_FIN
    } state_t;

    // which edge is expected next
    typedef enum logic [1:0] {
        PH_FIRST_RISE,
        PH_FALL,
        PH_CLOSE_RISE
    } phase_t;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [STAMP_W-1:0]  prev_reg, prev_next;
    logic [STAMP_W-1:0]  high_reg, high_next;
    logic [CNT_W-1:0]    pdone_reg, pdone_next;
    logic                stopped_reg, stopped_next;

    logic [TPS_W-1:0]    tps_reg;
    logic [MAXP_W-1:0]   maxp_reg;

    // per-period working registers
    logic [STAMP_W-1:0]  low_reg, low_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                last_reg, last_next;
    logic                err_reg, err_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;

    pdc_out_t            out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    logic                s_fire;
    logic [STAMP_W-1:0]  width;
    logic [PERIOD_W-1:0] period_w;
    logic [CMP_W-1:0]    done_inc;
    logic [CMP_W-1:0]    limit;
    pdc_div_cmd_t        div_cmd;
    logic                div_done;
    logic [STAMP_W-1:0]  div_q;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // down-counting timer: earlier stamp minus later stamp, modular
    assign width    = prev_reg - s_data.edge_time;
    assign period_w = {1'b0, high_reg} + {1'b0, width};
    assign done_inc = CMP_W'(pdone_reg) + CMP_W'(1);

    // effective limit: zero acts as one, clamp at the parameter
    always_comb begin
        if (maxp_reg == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(maxp_reg) > CMP_W'(MAX_PERIODS_LIMIT)) begin
            limit = CMP_W'(MAX_PERIODS_LIMIT);
        end else begin
            limit = CMP_W'(maxp_reg);
        end
    end

    pdc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .divisor  (period_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        prev_next    = prev_reg;
        high_next    = high_reg;
        pdone_next   = pdone_reg;
        stopped_next = stopped_reg;
        low_next     = low_reg;
        period_next  = period_reg;
        last_next    = last_reg;
        err_next     = err_reg;
        freq_next    = freq_reg;
        duty_next    = duty_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        div_cmd      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.opcode == OP_START) begin
                        phase_next   = PH_FIRST_RISE;
                        prev_next    = '0;
                        high_next    = '0;
                        pdone_next   = '0;
                        stopped_next = 1'b0;
                    end else if (!stopped_reg) begin
                        unique case (phase_reg)
                            PH_FALL: begin
                                high_next  = width;
                                prev_next  = s_data.edge_time;
                                phase_next = PH_CLOSE_RISE;
                            end
                            PH_CLOSE_RISE: begin
                                low_next    = width;
                                period_next = period_w;
                                err_next    = (period_w == '0);
                                freq_next   = '0;
                                duty_next   = '0;
                                pdone_next  = done_inc[CNT_W-1:0];
                                if (done_inc >= limit) begin
                                    last_next    = 1'b1;
                                    stopped_next = 1'b1;
                                end else begin
                                    last_next = 1'b0;
                                end
                                prev_next  = s_data.edge_time;
                                phase_next = PH_FALL;
                                state_next = (period_w == '0) ? ST_FIN : ST_MUL;
                            end
                            default: begin
                                prev_next  = s_data.edge_time;
                                phase_next = PH_FALL;
                            end
                        endcase
                    end
                end
            end
            ST_MUL: begin
                // frequency first: tick rate over period
                div_cmd.start    = 1'b1;
                div_cmd.steps    = FREQ_STEPS;
                div_cmd.rem_init = '0;
                div_cmd.bits     = tps_reg;
                state_next       = ST_WAIT_F;
            end
            ST_WAIT_F: begin
                if (div_done) begin
                    freq_next = div_q;
                    // duty quotient is below 128: upper bits go in as remainder
                    div_cmd.start    = 1'b1;
                    div_cmd.steps    = DUTY_STEPS;
                    div_cmd.rem_init = PERIOD_W'(prod_reg[PROD_W-1:DUTY_W]);
                    div_cmd.bits     = {prod_reg[DUTY_W-1:0], (STAMP_W-DUTY_W)'(0)};
                    state_next       = ST_WAIT_D;
                end
            end
            ST_WAIT_D: begin
                if (div_done) begin
                    duty_next  = div_q[DUTY_W-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.high_ticks   = high_reg;
                    out_next.low_ticks    = low_reg;
                    out_next.frequency    = freq_reg;
                    out_next.duty_percent = duty_reg;
                    out_next.period_error = err_reg;
                    out_next.last_period  = last_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_FIRST_RISE;
            prev_reg    <= '0;
            high_reg    <= '0;
            pdone_reg   <= '0;
            stopped_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            tps_reg     <= TPS_RESET;
            maxp_reg    <= MAXP_RESET;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            prev_reg    <= prev_next;
            high_reg    <= high_next;
            pdone_reg   <= pdone_next;
            stopped_reg <= stopped_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TICKS_PER_SECOND: tps_reg  <= cfg_data[TPS_W-1:0];
                    REG_MAX_PERIODS:      maxp_reg <= cfg_data[MAXP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        low_reg    <= low_next;
        period_reg <= period_next;
        last_reg   <= last_next;
        err_reg    <= err_next;
        freq_reg   <= freq_next;
        duty_reg   <= duty_next;
        out_reg    <= out_next;
        // 100 * high, ready before the duty division starts
        prod_reg   <= PROD_W'(high_reg) * DUTY_SCALE;
    end

endmodule

[sv/pdc_div.sv]
module pdc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pdc_pkg::pdc_div_cmd_t        cmd,
    input  logic [pdc_pkg::PERIOD_W-1:0] divisor,
    output logic                         done,
    output logic [pdc_pkg::STAMP_W-1:0]  quotient
);
    import pdc_pkg::*;

    logic [PERIOD_W-1:0] rem_reg;
    logic [STAMP_W-1:0]  sh_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [PERIOD_W:0]   cat;
    logic [PERIOD_W+1:0] diff;

    // restoring division, one quotient bit per cycle
    assign cat  = {rem_reg, sh_reg[STAMP_W-1]};
    assign diff = {1'b0, cat} - {2'b00, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                rem_reg  <= cmd.rem_init;
                sh_reg   <= cmd.bits;
                cnt_reg  <= cmd.steps;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!diff[PERIOD_W+1]) begin
                    rem_reg <= diff[PERIOD_W-1:0];
                end else begin
                    rem_reg <= cat[PERIOD_W-1:0];
                end
                sh_reg  <= {sh_reg[STAMP_W-2:0], ~diff[PERIOD_W+1]};
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

[verif/tb_pwm_period_duty_capture_core.sv]
`timescale 1ns / 1ps

module tb_pwm_period_duty_capture_core;

    import pdc_pkg::*;

    // run length guard and quiet time after the last expected word
    localparam int unsigned CYCLE_LIMIT  = 800_000;
    localparam int unsigned DRAIN_CYCLES = 80;

    // where the capture stands between edges
    typedef enum logic [1:0] {
        PH_WAIT_FIRST = 2'd0,
        PH_WAIT_FALL  = 2'd1,
        PH_WAIT_CLOSE = 2'd2
    } capture_phase_t;

    // mirror of the capture state, predicts one result word per closed period
    class period_scoreboard;
        logic [TPS_W-1:0]   tick_rate;
        logic [MAXP_W-1:0]  period_cap;
        capture_phase_t     edge_phase;
        logic [STAMP_W-1:0] last_stamp;
        logic [STAMP_W-1:0] high_width;
        int unsigned        periods_done;
        bit                 stopped;
        pdc_out_t           predicted_periods[$];
        int unsigned        mismatches;

        function new();
            tick_rate    = TPS_RESET;
            period_cap   = MAXP_RESET;
            edge_phase   = PH_WAIT_FIRST;
            last_stamp   = '0;
            high_width   = '0;
            periods_done = 0;
            stopped      = 1'b1;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TICKS_PER_SECOND)
                tick_rate = data[TPS_W-1:0];
            else
                period_cap = data[MAXP_W-1:0];
        endfunction

        function int pending();
            return predicted_periods.size();
        endfunction

        // accepted input word: update the mirror, queue a result if a period closes
        function void note_word(pdc_in_t w);
            logic [STAMP_W-1:0]  low_w;
            logic [PERIOD_W-1:0] period;
            longint unsigned     span;
            int unsigned         cap;
            pdc_out_t            r;
            if (w.opcode == OP_START) begin
                edge_phase   = PH_WAIT_FIRST;
                last_stamp   = '0;
                high_width   = '0;
                periods_done = 0;
                stopped      = 1'b0;
                return;
            end
            if (stopped)
                return;
            case (edge_phase)
                PH_WAIT_FALL: begin
                    high_width = last_stamp - w.edge_time;
                    last_stamp = w.edge_time;
                    edge_phase = PH_WAIT_CLOSE;
                end
                PH_WAIT_CLOSE: begin
                    low_w  = last_stamp - w.edge_time;
                    period = {1'b0, high_width} + {1'b0, low_w};
                    r = '0;
                    r.high_ticks = high_width;
                    r.low_ticks  = low_w;
                    if (period == '0) begin
                        r.period_error = 1'b1;
                    end else begin
                        span = period;
                        r.frequency    = FREQ_W'(longint'(tick_rate) / span);
                        r.duty_percent = DUTY_W'((longint'(high_width) * 100) / span);
                    end
                    cap = period_cap;
                    if (cap == 0)
                        cap = 1;
                    if (cap > DEF_MAX_PERIODS_LIMIT)
                        cap = DEF_MAX_PERIODS_LIMIT;
                    periods_done++;
                    if (periods_done >= cap) begin
                        r.last_period = 1'b1;
                        stopped = 1'b1;
                    end
                    predicted_periods.push_back(r);
                    last_stamp = w.edge_time;
                    edge_phase = PH_WAIT_FALL;
                end
                default: begin
                    // first rising edge, and the unused code as well
                    last_stamp = w.edge_time;
                    edge_phase = PH_WAIT_FALL;
                end
            endcase
        endfunction

        function void check_field(string name, logic [STAMP_W-1:0] want,
                                  logic [STAMP_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        // accepted result word against the oldest prediction
        function void check_word(pdc_out_t got);
            pdc_out_t want;
            if (predicted_periods.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, got);
                return;
            end
            want = predicted_periods.pop_front();
            check_field("high_ticks",   want.high_ticks,   got.high_ticks);
            check_field("low_ticks",    want.low_ticks,    got.low_ticks);
            check_field("frequency",    want.frequency,    got.frequency);
            check_field("duty_percent", want.duty_percent, got.duty_percent);
            check_field("period_error", want.period_error, got.period_error);
            check_field("last_period",  want.last_period,  got.last_period);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pdc_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    pdc_out_t              m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    period_scoreboard   sb;
    int unsigned        send_idle_pct = 10;
    int unsigned        recv_idle_pct = 10;
    int unsigned        stall_left    = 0;
    int unsigned        cycle_count   = 0;
    logic [STAMP_W-1:0] stamp_now     = '1;

    pwm_period_duty_capture_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // result side: stalls of random length, each started with a chance of recv_idle_pct in a thousand
    always @(negedge aclk) begin
        if (stall_left == 0 && $urandom_range(999) < recv_idle_pct)
            stall_left = $urandom_range(1, 30);
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // handshakes are sampled at the rising edge, before the block updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_word(m_data);
            if (s_valid && s_ready)
                sb.note_word(s_data);
        end
    end

    // timeout guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // one input word; entered and left at a falling edge, valid left high
    // so that a following word can go out without a dead cycle
    task automatic send_word(input pdc_in_t w);
        int unsigned gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 48) : 0;
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // drop valid, wait for every predicted word, then let the divider go quiet
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // register write, only while the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // random width: zeros, ones, full scale, short, medium and anything
    function automatic logic [STAMP_W-1:0] pick_width();
        case ($urandom_range(11))
            0, 1:    return '0;
            2:       return STAMP_W'(1);
            3:       return '1;
            4, 5:    return STAMP_W'($urandom_range(1, 16));
            6, 7, 8: return STAMP_W'($urandom_range(17, 5000));
            default: return STAMP_W'($urandom);
        endcase
    endfunction

    // the timer counts down, so each edge stamps below the one before (mod 2^24)
    function automatic pdc_in_t next_stamp_edge();
        stamp_now = stamp_now - pick_width();
        return {OP_EDGE, stamp_now};
    endfunction

    // a run of edges spaced by a fixed width
    task automatic send_even_edges(input int unsigned n, input logic [STAMP_W-1:0] step);
        repeat (n) begin
            send_word({OP_EDGE, stamp_now});
            stamp_now = stamp_now - step;
        end
    endtask

    // mostly clean edge trains, with fresh starts, and noise stamps that
    // break the timing; a stopped capture is restarted most of the time
    task automatic run_random(input int unsigned n);
        int unsigned r;
        pdc_in_t     w;
        send_word({OP_START, STAMP_W'($urandom)});
        repeat (n) begin
            r = $urandom_range(99);
            if (sb.stopped ? (r < 60) : (r < 3)) begin
                w = {OP_START, STAMP_W'($urandom)};
            end else if (r < 10) begin
                w = {OP_EDGE, STAMP_W'($urandom)};
                stamp_now = w.edge_time;
            end else begin
                w = next_stamp_edge();
            end
            send_word(w);
        end
    endtask

    initial begin
        logic [TPS_W-1:0]  tps;
        logic [MAXP_W-1:0] maxp;
        sb = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset register values
        send_word({OP_EDGE,  24'h123456});   // edge before any start is dropped
        send_word({OP_START, 24'hFFFFFF});   // stamp of a start is ignored
        send_word({OP_EDGE,  24'hFFFFFF});   // first rising edge
        send_word({OP_EDGE,  24'h000000});   // full-scale high width
        send_word({OP_EDGE,  24'hFFFFFF});   // low wraps to 1, period needs bit 24
        send_word({OP_EDGE,  24'hFFFFFF});
        send_word({OP_EDGE,  24'hFFFFFF});   // zero period, error flag
        send_word({OP_EDGE,  24'hFFFFFE});
        send_word({OP_EDGE,  24'hFFFFFD});   // period of two, half duty
        send_word({OP_EDGE,  24'hFFFFFD});
        send_word({OP_EDGE,  24'hFFFFFC});   // no high time
        send_word({OP_EDGE,  24'hFFFFFB});
        send_word({OP_EDGE,  24'hFFFFFB});   // full duty
        send_word({OP_EDGE,  24'h000010});
        send_word({OP_EDGE,  24'hFFFFF0});   // stamp wraps through zero
        send_word({OP_EDGE,  24'h7FFFFF});
        send_word({OP_START, 24'h000000});   // restart in the middle of a period
        send_word({OP_EDGE,  24'h500000});
        send_word({OP_EDGE,  24'h4FFF00});
        send_word({OP_EDGE,  24'h4FFE00});
        wait_drained();

        // single-period limit, upper data bits of the write are dropped
        cfg_write(REG_TICKS_PER_SECOND, '1);
        cfg_write(REG_MAX_PERIODS, 24'hABC001);
        send_word({OP_START, 24'h0F0F0F});
        send_even_edges(6, 24'd3);           // last on the first period, rest dropped
        wait_drained();

        // limit lowered below the periods already done
        cfg_write(REG_MAX_PERIODS, 24'd20);
        send_word({OP_START, 24'h000000});
        send_even_edges(9, 24'd37);
        wait_drained();
        cfg_write(REG_MAX_PERIODS, 24'd2);
        send_even_edges(4, 24'd41);          // next closed period is the last
        wait_drained();

        // random phases over several register settings, the first with no idling
        for (int k = 0; k < 8; k++) begin
            case (k)
                0: begin tps = TPS_RESET; maxp = 10'd4;   end
                1: begin tps = '0;        maxp = 10'd0;   end   // zero rate, limit 0
                2: begin tps = '1;        maxp = 10'd512; end
                3: begin tps = 24'd1;     maxp = 10'd2;   end
                default: begin
                    tps  = $urandom_range(1) ? TPS_W'($urandom)
                                             : TPS_W'($urandom_range(1, 5000));
                    maxp = MAXP_W'($urandom_range(0, 12));
                end
            endcase
            send_idle_pct = (k == 0) ? 0 : 10;
            recv_idle_pct = (k == 0) ? 0 : 10;
            cfg_write(REG_TICKS_PER_SECOND, tps);
            cfg_write(REG_MAX_PERIODS, {14'($urandom), maxp});
            run_random((k == 0) ? 120 : 80);
            wait_drained();
        end

        // limit above the build maximum clamps to it, so capture keeps running
        cfg_write(REG_MAX_PERIODS, {14'($urandom), 10'h3FF});
        send_word({OP_START, STAMP_W'($urandom)});
        repeat (40) send_word(next_stamp_edge());
        wait_drained();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[pwm_period_duty_capture_core.f]
sv/pdc_pkg.sv
sv/pdc_div.sv
sv/pwm_period_duty_capture_core.sv
verif/tb_pwm_period_duty_capture_core.sv
